[src/pjq_pkg.sv]
// Package for the priority job queue: payload types, codes and defaults.
package pjq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam logic [1:0] MODE_ADD     = 2'd0;
	localparam logic [1:0] MODE_REMOVE  = 2'd1;
	localparam logic [1:0] MODE_PROCESS = 2'd2;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_REMOVED   = 3'd1;
	localparam logic [2:0] ST_PROCESSED = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND  = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] user_tag;
		logic [15:0] document_tag;
		logic [15:0] page_count;
		logic        high_priority;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_user;
		logic [15:0] out_document;
		logic [15:0] out_pages;
		logic        out_priority;
		logic [4:0]  job_count;
	} rsp_t;

	typedef struct packed {
		logic        prio;
		logic [15:0] pages;
		logic [15:0] doc;
		logic [15:0] user;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[src/pjq_ram.sv]
// Generic simple dual-port RAM with registered read.
module pjq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/priority_job_queue.sv]
// Top level of the priority job queue.
// A bounded job queue kept as a circular buffer in one RAM (head pointer plus
// count). Add puts a high-priority job in front of the head and a normal job
// behind the tail with a single RAM write; its response is registered at the
// request transfer. Process reads the head (one RAM read) and answers from the
// registered read data. Remove scans from the head one entry per cycle and, on
// a hit, closes the gap by moving each later entry one slot toward the head,
// one entry per cycle; scan and shift together touch each queued entry once
// through the single RAM read port. One request is in flight at a time; the
// next can be taken in the cycle after its response transfer. Every request
// gives exactly one response with a status, the affected entry (zero
// otherwise) and the job count after the request.
module priority_job_queue #(
	parameter int unsigned QUEUE_DEPTH = pjq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pjq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pjq_pkg::rsp_t rsp
);

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned XW = AW + 2;

	typedef enum logic [1:0] {S_IDLE, S_POP, S_SRCH, S_SHIFT} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [15:0]       key_user_q;
	logic [15:0]       key_doc_q;
	pjq_pkg::entry_t   hit_q;
	logic              rsp_valid_q;
	pjq_pkg::rsp_t     rsp_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	pjq_pkg::entry_t   ram_wdata;
	logic [pjq_pkg::ENTRY_W-1:0] ram_rdata;
	pjq_pkg::entry_t   rd_entry;

	logic              accept;
	logic              full;
	logic              empty;
	logic              match;
	logic              more1;
	logic              more2;
	pjq_pkg::entry_t   new_entry;
	pjq_pkg::rsp_t     idle_rsp;

	// physical slot of a logical offset from the head
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (AW+1)'(QUEUE_DEPTH)) begin
			s = s - (AW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign rd_entry  = pjq_pkg::entry_t'(ram_rdata);
	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign accept    = req_valid && req_ready;
	assign full      = (XW'(count_q) >= XW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign match     = (rd_entry.user == key_user_q) && (rd_entry.doc == key_doc_q);
	// another entry behind the current offset / behind the next one
	assign more1     = (XW'(idx_q) + XW'(1)) < XW'(count_q);
	assign more2     = (XW'(idx_q) + XW'(2)) < XW'(count_q);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		new_entry.prio  = req.high_priority;
		new_entry.pages = req.page_count;
		new_entry.doc   = req.document_tag;
		new_entry.user  = req.user_tag;
	end

	// response loaded at request transfer; a non-empty remove/process fills in the rest later
	always_comb begin
		idle_rsp           = '0;
		idle_rsp.job_count = 5'(count_q);
		case (req.mode)
			pjq_pkg::MODE_ADD: begin
				if (full) begin
					idle_rsp.status = pjq_pkg::ST_FULL;
				end else begin
					idle_rsp.status    = pjq_pkg::ST_ADDED;
					idle_rsp.job_count = 5'(count_q + CW'(1));
				end
			end
			pjq_pkg::MODE_REMOVE, pjq_pkg::MODE_PROCESS: begin
				idle_rsp.status = pjq_pkg::ST_EMPTY;
			end
			default: begin
				idle_rsp.status = pjq_pkg::ST_NOTFOUND;
			end
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = new_entry;
		ram_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.mode == pjq_pkg::MODE_ADD && !full) begin
					ram_we = 1'b1;
					if (req.high_priority) begin
						ram_waddr = (head_q == '0) ? AW'(QUEUE_DEPTH - 1) : head_q - AW'(1);
					end else begin
						ram_waddr = slot(head_q, AW'(count_q));
					end
				end
			end
			S_SRCH: begin
				ram_raddr = slot(head_q, idx_q + AW'(1));
			end
			S_SHIFT: begin
				// move entry at offset idx+1 down to idx, fetch idx+2
				ram_we    = 1'b1;
				ram_waddr = slot(head_q, idx_q);
				ram_wdata = rd_entry;
				ram_raddr = slot(head_q, idx_q + AW'(2));
			end
			default: begin
				ram_raddr = head_q;
			end
		endcase
	end

	pjq_ram #(
		.WIDTH(pjq_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			key_user_q  <= '0;
			key_doc_q   <= '0;
			hit_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_user_q <= req.user_tag;
						key_doc_q  <= req.document_tag;
						idx_q      <= '0;
						rsp_q      <= idle_rsp;
						case (req.mode)
							pjq_pkg::MODE_ADD: begin
								rsp_valid_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CW'(1);
									if (req.high_priority) begin
										head_q <= (head_q == '0) ? AW'(QUEUE_DEPTH - 1)
											: head_q - AW'(1);
									end
								end
							end
							pjq_pkg::MODE_REMOVE, pjq_pkg::MODE_PROCESS: begin
								if (empty) begin
									rsp_valid_q <= 1'b1;
								end else begin
									state_q <= (req.mode == pjq_pkg::MODE_PROCESS) ? S_POP : S_SRCH;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_POP: begin
					rsp_valid_q        <= 1'b1;
					rsp_q.status       <= pjq_pkg::ST_PROCESSED;
					rsp_q.out_user     <= rd_entry.user;
					rsp_q.out_document <= rd_entry.doc;
					rsp_q.out_pages    <= rd_entry.pages;
					rsp_q.out_priority <= rd_entry.prio;
					rsp_q.job_count    <= 5'(count_q - CW'(1));
					count_q            <= count_q - CW'(1);
					head_q             <= slot(head_q, AW'(1));
					state_q            <= S_IDLE;
				end
				S_SRCH: begin
					if (match) begin
						hit_q <= rd_entry;
						if (more1) begin
							state_q <= S_SHIFT;
						end else begin
							rsp_valid_q        <= 1'b1;
							rsp_q.status       <= pjq_pkg::ST_REMOVED;
							rsp_q.out_user     <= rd_entry.user;
							rsp_q.out_document <= rd_entry.doc;
							rsp_q.out_pages    <= rd_entry.pages;
							rsp_q.out_priority <= rd_entry.prio;
							rsp_q.job_count    <= 5'(count_q - CW'(1));
							count_q            <= count_q - CW'(1);
							state_q            <= S_IDLE;
						end
					end else if (more1) begin
						idx_q <= idx_q + AW'(1);
					end else begin
						rsp_valid_q  <= 1'b1;
						rsp_q.status <= pjq_pkg::ST_NOTFOUND;
						state_q      <= S_IDLE;
					end
				end
				S_SHIFT: begin
					if (more2) begin
						idx_q <= idx_q + AW'(1);
					end else begin
						rsp_valid_q        <= 1'b1;
						rsp_q.status       <= pjq_pkg::ST_REMOVED;
						rsp_q.out_user     <= hit_q.user;
						rsp_q.out_document <= hit_q.doc;
						rsp_q.out_pages    <= hit_q.pages;
						rsp_q.out_priority <= hit_q.prio;
						rsp_q.job_count    <= 5'(count_q - CW'(1));
						count_q            <= count_q - CW'(1);
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(QUEUE_DEPTH))
		else $error("job count above queue depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !rsp_valid_q && state_q == S_IDLE)
		else $error("request taken while another is in flight");

	a_shift_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |=> $stable(count_q) || state_q == S_IDLE)
		else $error("count changed in the middle of a removal");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) && rsp_q.status == pjq_pkg::ST_FULL |->
			XW'(count_q) == XW'(QUEUE_DEPTH))
		else $error("add refused while queue not full");
`endif

endmodule

[tb/tb.sv]
// Testbench for the priority job queue: directed table, then random traffic vs a queue model.
module tb;

	localparam int unsigned DEPTH = pjq_pkg::QUEUE_DEPTH_DEF;
	localparam int unsigned N_RANDOM = 1900;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	pjq_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_ready;
	pjq_pkg::rsp_t  rsp;

	priority_job_queue #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Model of the queue contents, head at index 0.
	pjq_pkg::entry_t job_list[$];
	pjq_pkg::rsp_t   expected_rsps[$];
	int              mismatches;
	bit              stim_done;

	// Directed table row: the request, plus an optional typed-in answer.
	typedef struct {
		pjq_pkg::req_t req;
		bit            has_exp;
		pjq_pkg::rsp_t exp;
	} dir_row_t;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: sized for the slowest removes plus long gaps on both sides.
	initial begin
		#8000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic pjq_pkg::rsp_t apply_request(input pjq_pkg::req_t r);
		pjq_pkg::rsp_t   res;
		pjq_pkg::entry_t e;
		bit              found;
		res = '0;
		found = 1'b0;
		case (r.mode)
			pjq_pkg::MODE_ADD: begin
				if (job_list.size() >= DEPTH) begin
					res.status = pjq_pkg::ST_FULL;
				end else begin
					e.user = r.user_tag;
					e.doc = r.document_tag;
					e.pages = r.page_count;
					e.prio = r.high_priority;
					if (r.high_priority) job_list.push_front(e);
					else job_list.push_back(e);
					res.status = pjq_pkg::ST_ADDED;
				end
			end
			pjq_pkg::MODE_REMOVE: begin
				if (job_list.size() == 0) begin
					res.status = pjq_pkg::ST_EMPTY;
				end else begin
					res.status = pjq_pkg::ST_NOTFOUND;
					for (int i = 0; i < job_list.size() && !found; i++) begin
						if (job_list[i].user == r.user_tag && job_list[i].doc == r.document_tag) begin
							e = job_list[i];
							job_list.delete(i);
							found = 1'b1;
							res.status = pjq_pkg::ST_REMOVED;
							res.out_user = e.user;
							res.out_document = e.doc;
							res.out_pages = e.pages;
							res.out_priority = e.prio;
						end
					end
				end
			end
			pjq_pkg::MODE_PROCESS: begin
				if (job_list.size() == 0) begin
					res.status = pjq_pkg::ST_EMPTY;
				end else begin
					e = job_list.pop_front();
					res.status = pjq_pkg::ST_PROCESSED;
					res.out_user = e.user;
					res.out_document = e.doc;
					res.out_pages = e.pages;
					res.out_priority = e.prio;
				end
			end
			default: res.status = pjq_pkg::ST_NOTFOUND;	// unused mode: no-op
		endcase
		res.job_count = 5'(job_list.size());
		return res;
	endfunction

	// Mostly short gaps, now and then a long one, sometimes none at all.
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) return 0;
		if (sel < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random requests steered toward tags already queued so removes hit.
	function automatic pjq_pkg::req_t random_request();
		pjq_pkg::req_t r;
		int            sel;
		int            k;
		r.user_tag = 16'($urandom);
		r.document_tag = 16'($urandom);
		r.page_count = 16'($urandom);
		r.high_priority = 1'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 45) r.mode = pjq_pkg::MODE_ADD;
		else if (sel < 72) r.mode = pjq_pkg::MODE_REMOVE;
		else if (sel < 97) r.mode = pjq_pkg::MODE_PROCESS;
		else r.mode = pjq_pkg::MODE_UNUSED;
		// Small tag space sometimes, so duplicate keys exist in the queue.
		if ($urandom_range(0, 3) == 0) begin
			r.user_tag = 16'($urandom_range(0, 3));
			r.document_tag = 16'($urandom_range(0, 3));
		end
		if (r.mode == pjq_pkg::MODE_REMOVE && job_list.size() != 0 &&
			$urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, job_list.size() - 1);
			r.user_tag = job_list[k].user;
			r.document_tag = $urandom_range(0, 7) == 0 ? ~job_list[k].doc : job_list[k].doc;
		end
		return r;
	endfunction

	// Holds the request valid until transfer, then predicts the response.
	task automatic send_request(input pjq_pkg::req_t r, input bit has_exp,
		input pjq_pkg::rsp_t exp);
		pjq_pkg::rsp_t pred;
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pred = apply_request(r);
		if (has_exp && pred !== exp)
			$display("directed row disagrees with model: mode %0d", r.mode);
		expected_rsps.push_back(has_exp ? exp : pred);
	endtask

	// Stimulus
	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		int gap;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		stim_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue answers, then fill to full (first job with extreme field values), add when full, remove and process.
		row.has_exp = 1'b1;
		row.req = '{pjq_pkg::MODE_PROCESS, 16'h0, 16'h0, 16'h0, 1'b0};
		row.exp = '{pjq_pkg::ST_EMPTY, 16'h0, 16'h0, 16'h0, 1'b0, 5'd0};
		rows.push_back(row);
		row.req = '{pjq_pkg::MODE_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0, 1'b0};
		rows.push_back(row);
		row.req = '{pjq_pkg::MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
		row.exp = '{pjq_pkg::ST_NOTFOUND, 16'h0, 16'h0, 16'h0, 1'b0, 5'd0};
		rows.push_back(row);
		row.req = '{pjq_pkg::MODE_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
		row.exp = '{pjq_pkg::ST_ADDED, 16'h0, 16'h0, 16'h0, 1'b0, 5'd1};
		rows.push_back(row);
		row.has_exp = 1'b0;
		for (int i = 0; i < DEPTH - 1; i++) begin
			row.req = '{pjq_pkg::MODE_ADD, 16'(i), 16'(i ^ 5), 16'(i * 4099), 1'(i)};
			rows.push_back(row);
		end
		row.has_exp = 1'b1;
		row.req = '{pjq_pkg::MODE_ADD, 16'h1234, 16'h5678, 16'h9ABC, 1'b1};
		row.exp = '{pjq_pkg::ST_FULL, 16'h0, 16'h0, 16'h0, 1'b0, 5'(DEPTH)};
		rows.push_back(row);
		row.has_exp = 1'b0;
		row.req = '{pjq_pkg::MODE_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0, 1'b0};	// first normal job
		rows.push_back(row);
		row.req = '{pjq_pkg::MODE_REMOVE, 16'h0003, 16'h0006, 16'h0, 1'b0};	// urgent job hit
		rows.push_back(row);
		row.req = '{pjq_pkg::MODE_REMOVE, 16'h0003, 16'h0007, 16'h0, 1'b0};	// miss
		rows.push_back(row);
		row.req = '{pjq_pkg::MODE_PROCESS, 16'h0, 16'h0, 16'h0, 1'b0};
		rows.push_back(row);

		foreach (rows[i]) begin
			send_request(rows[i].req, rows[i].has_exp, rows[i].exp);
			gap = pick_gap();
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			send_request(random_request(), 1'b0, '0);
			gap = pick_gap();
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Response side: random back-pressure stretches and the compare.
	initial begin
		int            hold;
		pjq_pkg::rsp_t exp;
		rsp_ready = 1'b0;
		mismatches = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				hold--;
			end else begin
				rsp_ready <= 1'b1;
				hold = pick_gap();
			end
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected response %p", rsp);
				end else begin
					exp = expected_rsps.pop_front();
					if (rsp !== exp) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", exp, rsp);
					end
				end
			end
		end
	end

	// End of run: all requests sent and all responses seen, then a short drain.
	initial begin
		wait (stim_done);
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (4 * DEPTH + 10) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
